/* hdl/cosine_similarity_match_top_defines.svh */
`ifndef COSINE_SIMILARITY_MATCH_TOP_DEFINES_SVH
`define COSINE_SIMILARITY_MATCH_TOP_DEFINES_SVH

// Immediate implication, checked out of reset
`define CSSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle
`define CSSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cssm_pkg.sv */
package cssm_pkg;

    localparam int DOT_W  = 42;
    localparam int SQ_W   = 41;
    localparam int MAG_W  = 42;
    localparam int PROD_W = 84;
    localparam int WIDE_W = 116;
    localparam int SIM_W  = 16;
    localparam int BIT_W  = 4;
    localparam int R_SHIFT = 30;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sq_a;
        logic [SQ_W-1:0]         sq_b;
    } sums_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_P,
        BK_MUL_R,
        BK_TRIAL,
        BK_CHECK,
        BK_DONE
    } back_state_t;

endpackage

/* hdl/cssm_queue.sv */
module cssm_queue
    import cssm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sums_t     push_data,
    input  logic      pop,
    output sums_t     head,
    output q_status_t status
);

    sums_t      slot_reg [2];
    logic       wr_reg;
    logic       wr_next;
    logic       rd_reg;
    logic       rd_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = ~wr_reg;
        end
        if (pop)
        begin
            rd_next = ~rd_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    assign head         = slot_reg[rd_reg];
    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);

endmodule

/* hdl/cssm_front.sv */
module cssm_front
    import cssm_pkg::*;
#(
    parameter int EMBED_MAX = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] elem_a,
    input  logic signed [15:0] elem_b,
    input  logic               last_elem,
    input  q_status_t          q_status,
    output logic               q_push,
    output sums_t              q_data
);

    localparam int CNT_W = $clog2(EMBED_MAX + 1);

    logic signed [DOT_W-1:0] dot_reg;
    logic signed [DOT_W-1:0] dot_next;
    logic [SQ_W-1:0]         sq_a_reg;
    logic [SQ_W-1:0]         sq_a_next;
    logic [SQ_W-1:0]         sq_b_reg;
    logic [SQ_W-1:0]         sq_b_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic signed [31:0]      prod_ab;
    logic signed [31:0]      prod_aa;
    logic signed [31:0]      prod_bb;
    logic signed [DOT_W:0]   dot_wide;
    logic [SQ_W:0]           sq_a_wide;
    logic [SQ_W:0]           sq_b_wide;
    logic signed [DOT_W-1:0] dot_acc;
    logic [SQ_W-1:0]         sq_a_acc;
    logic [SQ_W-1:0]         sq_b_acc;
    logic                    room;
    logic                    accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign room     = (count_reg < CNT_W'(EMBED_MAX));

    always_comb
    begin
        prod_ab   = elem_a * elem_b;
        prod_aa   = elem_a * elem_a;
        prod_bb   = elem_b * elem_b;
        dot_wide  = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(prod_ab);
        sq_a_wide = {1'b0, sq_a_reg} + (SQ_W+1)'(prod_aa[30:0]);
        sq_b_wide = {1'b0, sq_b_reg} + (SQ_W+1)'(prod_bb[30:0]);

        dot_acc  = dot_reg;
        sq_a_acc = sq_a_reg;
        sq_b_acc = sq_b_reg;
        if (room)
        begin
            // clamp on carry out of the signed range
            if (dot_wide[DOT_W] != dot_wide[DOT_W-1])
            begin
                dot_acc = dot_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                          : {1'b0, {(DOT_W-1){1'b1}}};
            end
            else
            begin
                dot_acc = dot_wide[DOT_W-1:0];
            end
            sq_a_acc = sq_a_wide[SQ_W] ? {SQ_W{1'b1}} : sq_a_wide[SQ_W-1:0];
            sq_b_acc = sq_b_wide[SQ_W] ? {SQ_W{1'b1}} : sq_b_wide[SQ_W-1:0];
        end

        dot_next    = dot_reg;
        sq_a_next   = sq_a_reg;
        sq_b_next   = sq_b_reg;
        count_next  = count_reg;
        q_push      = 1'b0;
        q_data.dot  = dot_acc;
        q_data.sq_a = sq_a_acc;
        q_data.sq_b = sq_b_acc;
        if (accept)
        begin
            if (last_elem)
            begin
                q_push     = 1'b1;
                dot_next   = '0;
                sq_a_next  = '0;
                sq_b_next  = '0;
                count_next = '0;
            end
            else
            begin
                dot_next  = dot_acc;
                sq_a_next = sq_a_acc;
                sq_b_next = sq_b_acc;
                if (room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            sq_a_reg  <= '0;
            sq_b_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            dot_reg   <= dot_next;
            sq_a_reg  <= sq_a_next;
            sq_b_reg  <= sq_b_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/cssm_back.sv */
module cssm_back
    import cssm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_status_t          q_status,
    input  sums_t              head,
    output logic               q_pop,
    input  logic signed [15:0] threshold,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] similarity,
    output logic               is_similar,
    output logic               zero_magnitude
);

    back_state_t        state_reg;
    back_state_t        state_next;

    logic               zero_reg;
    logic               zero_next;
    logic               neg_reg;
    logic               neg_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   mag_next;
    logic [PROD_W-1:0]  mcand_reg;
    logic [PROD_W-1:0]  mcand_next;
    logic [MAG_W-1:0]   mplier_reg;
    logic [MAG_W-1:0]   mplier_next;
    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  acc_next;
    logic [WIDE_W-1:0]  p_reg;
    logic [WIDE_W-1:0]  p_next;
    logic [WIDE_W-1:0]  r_reg;
    logic [WIDE_W-1:0]  r_next;
    logic [WIDE_W-1:0]  t_reg;
    logic [WIDE_W-1:0]  t_next;
    logic [WIDE_W-1:0]  u_reg;
    logic [WIDE_W-1:0]  u_next;
    logic [WIDE_W-1:0]  trial_reg;
    logic [WIDE_W-1:0]  trial_next;
    logic [SIM_W-1:0]   m_reg;
    logic [SIM_W-1:0]   m_next;
    logic [BIT_W-1:0]   k_reg;
    logic [BIT_W-1:0]   k_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] sim_reg;
    logic signed [15:0] sim_next;
    logic               similar_reg;
    logic               similar_next;
    logic               zmag_reg;
    logic               zmag_next;

    logic               head_zero;
    logic               out_free;
    logic               mul_done;
    logic [SIM_W-1:0]   capped;
    logic signed [15:0] sim_val;

    assign head_zero = (head.sq_a == '0) || (head.sq_b == '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_done  = (mplier_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = head_zero ? BK_DONE : BK_MUL_P;
                end
            end
            BK_MUL_P:
            begin
                if (mul_done)
                begin
                    state_next = BK_MUL_R;
                end
            end
            BK_MUL_R:
            begin
                if (mul_done)
                begin
                    state_next = BK_TRIAL;
                end
            end
            BK_TRIAL:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (k_reg == '0)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_TRIAL;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // final result from the root search
    always_comb
    begin
        capped = (m_reg > 16'd32768) ? 16'd32768 : m_reg;
        if (zero_reg)
        begin
            sim_val = '0;
        end
        else if (neg_reg)
        begin
            sim_val = 16'(17'd0 - {1'b0, capped});
        end
        else
        begin
            sim_val = (m_reg > 16'd32767) ? 16'sd32767 : $signed(m_reg);
        end
    end

    always_comb
    begin
        q_pop          = 1'b0;
        zero_next      = zero_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        trial_next     = trial_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        sim_next       = sim_reg;
        similar_next   = similar_reg;
        zmag_next      = zmag_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop       = 1'b1;
                    zero_next   = head_zero;
                    neg_next    = head.dot[DOT_W-1];
                    mag_next    = head.dot[DOT_W-1] ? (~head.dot + MAG_W'(1)) : head.dot;
                    mcand_next  = PROD_W'(head.sq_a);
                    mplier_next = MAG_W'(head.sq_b);
                    acc_next    = '0;
                    t_next      = '0;
                    u_next      = '0;
                    m_next      = '0;
                    k_next      = BIT_W'(SIM_W - 1);
                end
            end
            BK_MUL_P, BK_MUL_R:
            begin
                if (mul_done)
                begin
                    if (state_reg == BK_MUL_P)
                    begin
                        p_next      = WIDE_W'(acc_reg);
                        mcand_next  = PROD_W'(mag_reg);
                        mplier_next = mag_reg;
                        acc_next    = '0;
                    end
                    else
                    begin
                        r_next = WIDE_W'(acc_reg) << R_SHIFT;
                    end
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            BK_TRIAL:
            begin
                // (m + 2^k)^2 P = m^2 P + 2^(k+1) mP + 2^(2k) P
                trial_next = t_reg + (u_reg << ({1'b0, k_reg} + 5'd1))
                           + (p_reg << {k_reg, 1'b0});
            end
            BK_CHECK:
            begin
                if (trial_reg <= r_reg)
                begin
                    t_next        = trial_reg;
                    u_next        = u_reg + (p_reg << k_reg);
                    m_next[k_reg] = 1'b1;
                end
                if (k_reg != '0)
                begin
                    k_next = k_reg - BIT_W'(1);
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sim_next       = sim_val;
                    similar_next   = !zero_reg && (sim_val > threshold);
                    zmag_next      = zero_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg    <= zero_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        acc_reg     <= acc_next;
        p_reg       <= p_next;
        r_reg       <= r_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        trial_reg   <= trial_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        sim_reg     <= sim_next;
        similar_reg <= similar_next;
        zmag_reg    <= zmag_next;
    end

    assign out_valid      = out_valid_reg;
    assign similarity     = sim_reg;
    assign is_similar     = similar_reg;
    assign zero_magnitude = zmag_reg;

endmodule

/* hdl/cosine_similarity_match_top.sv */
// Cosine similarity of two streamed embedding vectors against a threshold.
// Input channel (in_valid / in_stall): one Q1.15 element pair per transaction,
// last_elem marks the final pair. Pairs are taken at one per cycle while in_stall
// is low; sums saturate, and pairs beyond EMBED_MAX are not accumulated.
// Each last pair queues its sums (two-entry queue) and clears the front end.
// The back end works one vector pair at a time: a shift-add multiplier for
// sum_a*sum_b and dot^2 (stepping through multiplier bits up to the top set
// bit), then a 16-bit root search with a trial and a check state per bit,
// then the done state loads the output register. The multiplier is shared
// by both products; zero-magnitude vectors go from idle straight to done.
// The front end stalls only when the queue holds two pending vectors.
// Output channel (out_valid / out_stall): similarity, is_similar and
// zero_magnitude, held while out_stall is high.
// Threshold: write on cfg_valid (cfg_ready is always high) while idle.
// Reset clears sums, queue, back-end state and sets the threshold to 0.
`include "cosine_similarity_match_top_defines.svh"

module cosine_similarity_match_top
    import cssm_pkg::*;
#(
    parameter int EMBED_MAX = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [15:0] match_threshold,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] elem_a,
    input  logic signed [15:0] elem_b,
    input  logic               last_elem,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] similarity,
    output logic               is_similar,
    output logic               zero_magnitude
);

    logic signed [15:0] threshold_reg;
    logic               q_push;
    logic               q_pop;
    sums_t              q_in;
    sums_t              q_head;
    q_status_t          q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= match_threshold;
        end
    end

    cssm_front #(
        .EMBED_MAX (EMBED_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last_elem (last_elem),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    cssm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    cssm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head           (q_head),
        .q_pop          (q_pop),
        .threshold      (threshold_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .similarity     (similarity),
        .is_similar     (is_similar),
        .zero_magnitude (zero_magnitude)
    );

    `CSSM_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_status.full,
                     "push into full queue")
    `CSSM_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !q_status.empty,
                     "pop from empty queue")
    `CSSM_ASSERT_IMP(a_zero_result, clk, rst_n, out_valid && zero_magnitude,
                     (similarity == 16'sd0) && !is_similar,
                     "zero magnitude with non-zero result")
    `CSSM_ASSERT_NXT(a_pop_push_cnt, clk, rst_n, q_pop && !q_push && q_status.full,
                     !q_status.full && !q_status.empty, "queue count slip")

endmodule

/* verif/tb_cosine_similarity_match_top.sv */
module tb_cosine_similarity_match_top;
    import cssm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EMBED_MAX  = 512;
    localparam int HOLD_OFF   = 300;
    localparam int WATCHDOG   = 40000;
    localparam longint DOT_HI = (64'sd1 <<< 41) - 1;
    localparam longint DOT_LO = -(64'sd1 <<< 41);
    localparam longint SQ_HI  = (64'sd1 <<< 41) - 1;

    typedef struct {
        logic signed [15:0] sim;
        logic               hit;
        logic               zero;
    } match_t;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        logic               typed;
        match_t             want;
    } pair_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic signed [15:0] match_threshold = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] elem_a = '0;
    logic signed [15:0] elem_b = '0;
    logic               last_elem = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] similarity;
    logic               is_similar;
    logic               zero_magnitude;

    // side-band for directed rows with a typed expectation
    logic   row_typed = 1'b0;
    match_t row_want;

    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     errors = 0;
    int     quiet_cycles = 0;

    match_t results_due[$];
    longint dot_acc = 0;
    longint sq_a_acc = 0;
    longint sq_b_acc = 0;
    int     pairs_taken = 0;
    logic signed [15:0] thresh_now = '0;

    cosine_similarity_match_top #(.EMBED_MAX(EMBED_MAX)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .match_threshold(match_threshold),
        .in_valid(in_valid), .in_stall(in_stall),
        .elem_a(elem_a), .elem_b(elem_b), .last_elem(last_elem),
        .out_valid(out_valid), .out_stall(out_stall),
        .similarity(similarity), .is_similar(is_similar), .zero_magnitude(zero_magnitude)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // truncated Q1.15 cosine: largest m with m^2*sa*sb <= dot^2*2^30
    function automatic logic signed [15:0] cos_q15(longint dot, longint sa, longint sb);
        logic [127:0] mag, rhs, prod, trial;
        logic [16:0]  lo, hi, mid;
        logic         neg;
        neg  = dot < 0;
        mag  = neg ? 128'(-dot) : 128'(dot);
        rhs  = (mag * mag) << 30;
        prod = 128'(sa) * 128'(sb);
        lo   = 0;
        hi   = 17'd32768;
        while (lo < hi)
        begin
            mid   = (lo + hi + 1) / 2;
            trial = prod * (128'(mid) * 128'(mid));
            if (trial <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (neg)
            return 16'(-$signed({1'b0, lo}));
        return (lo > 17'd32767) ? 16'sd32767 : 16'(lo);
    endfunction

    function automatic match_t take_pair(logic signed [15:0] a, logic signed [15:0] b,
                                         logic last);
        match_t r;
        longint d, sa, sb;
        r = '{sim: '0, hit: 1'b0, zero: 1'b0};
        if (pairs_taken < EMBED_MAX)
        begin
            d  = dot_acc + longint'(a) * longint'(b);
            sa = sq_a_acc + longint'(a) * longint'(a);
            sb = sq_b_acc + longint'(b) * longint'(b);
            dot_acc  = (d > DOT_HI) ? DOT_HI : ((d < DOT_LO) ? DOT_LO : d);
            sq_a_acc = (sa > SQ_HI) ? SQ_HI : sa;
            sq_b_acc = (sb > SQ_HI) ? SQ_HI : sb;
            pairs_taken++;
        end
        if (last)
        begin
            if (sq_a_acc == 0 || sq_b_acc == 0)
                r.zero = 1'b1;
            else
            begin
                r.sim = cos_q15(dot_acc, sq_a_acc, sq_b_acc);
                r.hit = r.sim > thresh_now;
            end
            dot_acc = 0;
            sq_a_acc = 0;
            sq_b_acc = 0;
            pairs_taken = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        match_t r, w;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                thresh_now <= match_threshold;
            if (in_valid && !in_stall)
            begin
                r = take_pair(elem_a, elem_b, last_elem);
                if (last_elem)
                    results_due.push_back(row_typed ? row_want : r);
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result, similarity", similarity, 0);
                else
                begin
                    w = results_due.pop_front();
                    if (similarity !== w.sim)
                        report_mismatch("similarity", similarity, w.sim);
                    if (is_similar !== w.hit)
                        report_mismatch("is_similar", is_similar, w.hit);
                    if (zero_magnitude !== w.zero)
                        report_mismatch("zero_magnitude", zero_magnitude, w.zero);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("FAIL cosine_similarity_match_top");
                $finish;
            end
        end
    end

    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last,
                             logic typed = 1'b0, match_t want = '{0, 0, 0});
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        elem_a    <= a;
        elem_b    <= b;
        last_elem <= last;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(logic signed [15:0] v);
        drain();
        repeat (HOLD_OFF) @(posedge clk);
        cfg_valid       <= 1'b1;
        match_threshold <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_elem(int style, logic signed [15:0] other);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return other;
            3: return -other;
            4: return 16'(other + $signed($urandom_range(0, 512)) - 256);
            default: return '0;
        endcase
    endfunction

    // one vector pair of random shape; returns pairs sent
    task automatic send_vector(output int sent);
        int len, style, zero_side;
        logic signed [15:0] a, b;
        len       = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        style     = $urandom_range(0, 5);
        zero_side = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < len; i++)
        begin
            a = 16'($urandom);
            b = pick_elem(style, a);
            if (zero_side == 1)
                a = '0;
            if (zero_side == 2)
                b = '0;
            send_pair(a, b, i == len - 1);
        end
        sent = len;
    endtask

    pair_row_t directed[] = '{
        '{16'sd0,      16'sd0,      1'b1, 1'b1, '{16'sd0,      1'b0, 1'b1}},
        '{16'sd32767,  16'sd32767,  1'b1, 1'b1, '{16'sd32767,  1'b1, 1'b0}},
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, '{16'sd32767,  1'b1, 1'b0}},
        '{-16'sd32768, 16'sd32767,  1'b1, 1'b1, '{-16'sd32768, 1'b0, 1'b0}},
        '{16'sd32767,  -16'sd32768, 1'b1, 1'b1, '{-16'sd32768, 1'b0, 1'b0}},
        '{16'sd5,      16'sd0,      1'b1, 1'b1, '{16'sd0,      1'b0, 1'b1}},
        '{16'sd0,      -16'sd7,     1'b1, 1'b1, '{16'sd0,      1'b0, 1'b1}},
        '{16'sd1,      16'sd1,      1'b0, 1'b0, '{0, 0, 0}},
        '{16'sd1,      -16'sd1,     1'b1, 1'b0, '{0, 0, 0}},
        '{16'sd1000,   16'sd2000,   1'b0, 1'b0, '{0, 0, 0}},
        '{-16'sd300,   16'sd50,     1'b0, 1'b0, '{0, 0, 0}},
        '{16'sd12345,  -16'sd54,    1'b1, 1'b0, '{0, 0, 0}},
        '{16'sd3,      16'sd4,      1'b0, 1'b0, '{0, 0, 0}},
        '{16'sd4,      -16'sd3,     1'b1, 1'b0, '{0, 0, 0}},
        '{16'sd0,      16'sd9,      1'b0, 1'b0, '{0, 0, 0}},
        '{16'sd9,      16'sd0,      1'b1, 1'b0, '{0, 0, 0}},
        '{-16'sd1,     -16'sd1,     1'b1, 1'b1, '{16'sd32767,  1'b1, 1'b0}}
    };

    initial
    begin
        int sent, total;
        int idle_set[4]  = '{0, 74, 0, 9};
        int stall_set[4] = '{0, 0, 74, 9};
        logic signed [15:0] thresh_set[5] = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd16384,
                                              -16'sd100};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_pair(directed[i].a, directed[i].b, directed[i].last,
                      directed[i].typed, directed[i].want);

        // pairs past the limit are dropped, the marked last one included
        write_threshold(16'($urandom));
        for (int i = 0; i < EMBED_MAX + 6; i++)
            send_pair(16'($urandom), 16'($urandom), (i % 3 == 2) && i >= EMBED_MAX - 1);
        send_pair(16'sd77, -16'sd77, 1'b1);
        drain();

        // count the directed and limit pairs towards the item budget
        total = directed.size() + EMBED_MAX + 7;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(ph == 4 ? 16'($urandom) : thresh_set[ph]);
            send_idle_pct = idle_set[ph % 4];
            stall_pct     = stall_set[ph % 4];
            for (int n = 0; n < 120 && total < 1150; n += sent)
            begin
                send_vector(sent);
                total += sent;
                if (ph == 1 && n > 60 && n < 70)
                    drain();
            end
        end
        write_threshold(thresh_set[4]);
        send_idle_pct = 30;
        stall_pct     = 30;
        while (total < 1150)
        begin
            send_vector(sent);
            total += sent;
        end

        drain();
        repeat (HOLD_OFF) @(posedge clk);
        if (errors == 0)
            $display("PASS cosine_similarity_match_top");
        else
            $display("FAIL cosine_similarity_match_top");
        $finish;
    end
endmodule
